### rtl/tfi_pkg.sv
// ----------------------------------------------------------------------------
// tfi_pkg
// Shared constants, codes and controller/datapath interface types for the
// timestamp frame interpolator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tfi_pkg;

  // Log geometry
  localparam int LOG_DEPTH = 1024;
  localparam int IDX_W     = $clog2(LOG_DEPTH);
  localparam int CNT_W     = $clog2(LOG_DEPTH + 1);

  // Field widths
  localparam int TIME_W  = 63;
  localparam int FRAME_W = 40;
  localparam int OUT_W   = 48;
  localparam int FPN_W   = 32;
  localparam int BLK_W   = 17;
  localparam int CFG_W   = 40;
  localparam int ENTRY_W = TIME_W + FRAME_W;

  // Serial arithmetic
  localparam int WORD_W   = 64;
  localparam int PROD_W   = 2 * WORD_W;
  localparam int STEP_W   = $clog2(PROD_W);
  localparam logic [STEP_W-1:0] MUL_LAST = STEP_W'(WORD_W - 1);
  localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(PROD_W - 1);

  // Register reset values
  localparam logic [FPN_W-1:0]   FPN_RESET     = FPN_W'(206158);
  localparam logic [BLK_W-1:0]   BLK_RESET     = BLK_W'(1024);
  localparam logic [FRAME_W-1:0] MAX_RESET     = FRAME_W'(28800000);
  localparam logic [BLK_W-1:0]   DEFAULT_BLOCK = BLK_W'(1024);

  typedef enum logic [1:0] {
    OP_STAMP = 2'd0,
    OP_QUERY = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    CFG_FPN = 2'd0,
    CFG_BLK = 2'd1,
    CFG_MAX = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    RD_ZERO,
    RD_LAST,
    RD_MID,
    RD_LO,
    RD_HI
  } rd_sel_t;

  typedef enum logic [2:0] {
    BND_NONE,
    BND_FIRST,
    BND_LAST,
    BND_FULL,
    BND_NARROW
  } bound_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_EXEC,
    S_RD0,
    S_CK0,
    S_RDL,
    S_CKL,
    S_SRD,
    S_SCK,
    S_RDA,
    S_RDB,
    S_LATB,
    S_SETS,
    S_SETP,
    S_MUL,
    S_DIV,
    S_RND,
    S_COMB
  } state_t;

  typedef struct packed {
    logic    accept;
    logic    exec;
    rd_sel_t rd_sel;
    bound_t  bound;
    logic    lat_a;
    logic    lat_b;
    logic    setup_single;
    logic    setup_pair;
    logic    mul_step;
    logic    div_step;
    logic    rnd;
    logic    emit_query;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       count_zero;
    logic       count_one;
    logic       t_le_rd;
    logic       t_ge_rd;
    logic       span_gt1;
    logic       dmag_zero;
    logic       step_zero;
    logic       single;
  } stat_t;

endpackage

`default_nettype wire

### rtl/timestamp_frame_interpolator.sv
// ----------------------------------------------------------------------------
// timestamp_frame_interpolator
// Block stamp log with host time to frame mapping by binary search and
// exact linear interpolation.
// ----------------------------------------------------------------------------
// Usage:
//   Issue a transaction by raising start with operation and host_time_ns
//   while busy is low; it is taken at that clock edge. Exactly one result
//   follows, shown for one cycle with done high: frame_index, frame_valid,
//   block_stored, dropped_total. The receiver cannot stall the block.
//   Stamp, clear, unused codes and queries on an empty log finish without
//   search or arithmetic. Query with one stamp: the result is computed by
//   the 64-step shift-add multiplier. Query with two or more stamps: the
//   result is computed by the binary search, with a log read and a compare
//   per search step, then the 64-step multiplier and the 128-step restoring
//   divider, which are skipped when the two neighbor stamps have equal times.
//   A new transaction may be taken in the cycle done is high.
//   Configuration writes (cfg_write, cfg_index, cfg_data) take effect at
//   once; the user must make them only while the block is idle (unenforced).
//   Reset (rst, synchronous) empties the log, zeroes both frame counts and
//   restores register defaults; the log memory itself is not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module timestamp_frame_interpolator
  import tfi_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_write,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [CFG_W-1:0]    cfg_data,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [1:0]          operation,
  input  wire logic [TIME_W-1:0]   host_time_ns,
  output logic                     done,
  output logic signed [OUT_W-1:0]  frame_index,
  output logic                     frame_valid,
  output logic                     block_stored,
  output logic [FRAME_W-1:0]       dropped_total
);

  cmd_t  cmd;
  stat_t stat;

  // Sequencer
  tfi_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  // Log, counts and arithmetic
  tfi_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .operation     (operation),
    .host_time_ns  (host_time_ns),
    .cmd           (cmd),
    .stat          (stat),
    .done          (done),
    .frame_index   (frame_index),
    .frame_valid   (frame_valid),
    .block_stored  (block_stored),
    .dropped_total (dropped_total)
  );

  // Accepted transaction keeps the block busy next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  // One result per transaction: no back-to-back strobes
  a_single_strobe: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for two cycles");

  // Stored block always carries a valid frame
  a_stored_valid: assert property (@(posedge clk) disable iff (rst)
    (done && block_stored) |-> frame_valid)
    else $error("stored block without valid frame");

  // Invalid results carry frame zero
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !frame_valid) |-> (frame_index == '0))
    else $error("invalid result with nonzero frame");

endmodule

`default_nettype wire

### rtl/tfi_ctrl.sv
// ----------------------------------------------------------------------------
// tfi_ctrl
// Sequencer: dispatches each transaction, walks the binary search and
// steps the shared serial multiply and divide.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tfi_ctrl
  import tfi_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  start,
  input  stat_t      stat,
  output cmd_t       cmd,
  output logic       busy
);

  state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (start) state_next = S_EXEC;
      S_EXEC: begin
        if (stat.op == OP_QUERY && !stat.count_zero) state_next = S_RD0;
        else state_next = S_IDLE;
      end
      S_RD0: state_next = S_CK0;
      S_CK0: begin
        if (stat.count_one) state_next = S_SETS;
        else if (stat.t_le_rd) state_next = S_RDA;
        else state_next = S_RDL;
      end
      S_RDL: state_next = S_CKL;
      S_CKL: state_next = stat.t_ge_rd ? S_RDA : S_SRD;
      S_SRD: state_next = stat.span_gt1 ? S_SCK : S_RDA;
      S_SCK: state_next = S_SRD;
      S_RDA: state_next = S_RDB;
      S_RDB: state_next = S_LATB;
      S_LATB: state_next = S_SETP;
      S_SETS: state_next = S_MUL;
      S_SETP: state_next = stat.dmag_zero ? S_COMB : S_MUL;
      S_MUL: begin
        if (stat.step_zero) state_next = stat.single ? S_RND : S_DIV;
      end
      S_DIV: if (stat.step_zero) state_next = S_RND;
      S_RND: state_next = S_COMB;
      S_COMB: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Datapath commands
  always_comb begin
    cmd = '0;
    cmd.rd_sel = RD_ZERO;
    cmd.bound = BND_NONE;
    case (state)
      S_IDLE: cmd.accept = start;
      S_EXEC: cmd.exec = 1'b1;
      S_RD0: cmd.rd_sel = RD_ZERO;
      S_CK0: begin
        if (stat.count_one) cmd.lat_a = 1'b1;
        else if (stat.t_le_rd) cmd.bound = BND_FIRST;
      end
      S_RDL: cmd.rd_sel = RD_LAST;
      S_CKL: cmd.bound = stat.t_ge_rd ? BND_LAST : BND_FULL;
      S_SRD: cmd.rd_sel = RD_MID;
      S_SCK: cmd.bound = BND_NARROW;
      S_RDA: cmd.rd_sel = RD_LO;
      S_RDB: begin
        cmd.rd_sel = RD_HI;
        cmd.lat_a = 1'b1;
      end
      S_LATB: cmd.lat_b = 1'b1;
      S_SETS: cmd.setup_single = 1'b1;
      S_SETP: cmd.setup_pair = 1'b1;
      S_MUL: cmd.mul_step = 1'b1;
      S_DIV: cmd.div_step = 1'b1;
      S_RND: cmd.rnd = 1'b1;
      S_COMB: cmd.emit_query = 1'b1;
      default: cmd = '0;
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

`default_nettype wire

### rtl/tfi_datapath.sv
// ----------------------------------------------------------------------------
// tfi_datapath
// Stamp log memory, counts, configuration registers, search bounds and
// the shared shift-add multiplier / restoring divider with result rounding.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tfi_datapath
  import tfi_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_write,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [CFG_W-1:0]    cfg_data,
  input  wire logic [1:0]          operation,
  input  wire logic [TIME_W-1:0]   host_time_ns,
  input  cmd_t                     cmd,
  output stat_t                    stat,
  output logic                     done,
  output logic signed [OUT_W-1:0]  frame_index,
  output logic                     frame_valid,
  output logic                     block_stored,
  output logic [FRAME_W-1:0]       dropped_total
);

  // Configuration and counts
  logic [FPN_W-1:0]   frames_per_ns_q32;
  logic [BLK_W-1:0]   block_frames;
  logic [FRAME_W-1:0] max_capture_frames;
  logic [CNT_W-1:0]   entry_count;
  logic [FRAME_W-1:0] captured_frames;
  logic [FRAME_W-1:0] dropped_frames;

  // Transaction and search registers
  logic [1:0]         op;
  logic [TIME_W-1:0]  t;
  logic [IDX_W-1:0]   lo, hi;
  logic [TIME_W-1:0]  a_time, b_time;
  logic [FRAME_W-1:0] a_frame, b_frame;

  // Arithmetic registers
  logic [WORD_W-1:0]  mcand;
  logic [PROD_W-1:0]  prod;
  logic [WORD_W-1:0]  rem;
  logic [TIME_W-1:0]  divisor;
  logic [STEP_W-1:0]  step;
  logic               single;
  logic               neg;
  logic [FRAME_W-1:0] base;
  logic [WORD_W-1:0]  mag;

  // Log memory
  logic [ENTRY_W-1:0] mem [LOG_DEPTH];
  logic [ENTRY_W-1:0] rdata;
  logic [IDX_W-1:0]   raddr;
  logic [TIME_W-1:0]  rd_time;
  logic [FRAME_W-1:0] rd_frame;

  assign rd_time  = rdata[ENTRY_W-1:FRAME_W];
  assign rd_frame = rdata[FRAME_W-1:0];

  // Search index helpers
  logic [CNT_W-1:0] n_m1, n_m2;
  logic [IDX_W:0]   mid_sum;
  logic [IDX_W-1:0] mid;

  assign n_m1    = entry_count - CNT_W'(1);
  assign n_m2    = entry_count - CNT_W'(2);
  assign mid_sum = {1'b0, lo} + {1'b0, hi};
  assign mid     = mid_sum[IDX_W:1];

  always_comb begin
    case (cmd.rd_sel)
      RD_ZERO: raddr = '0;
      RD_LAST: raddr = n_m1[IDX_W-1:0];
      RD_MID:  raddr = mid;
      RD_LO:   raddr = lo;
      RD_HI:   raddr = hi;
      default: raddr = '0;
    endcase
  end

  // Stamp admission
  logic [BLK_W-1:0]   blk;
  logic [FRAME_W:0]   cap_sum;
  logic [FRAME_W:0]   drop_sum;
  logic [FRAME_W-1:0] drop_sat;
  logic               fits;
  logic               do_store;

  assign blk      = (block_frames == '0) ? DEFAULT_BLOCK : block_frames;
  assign cap_sum  = {1'b0, captured_frames} + (FRAME_W+1)'(blk);
  assign drop_sum = {1'b0, dropped_frames} + (FRAME_W+1)'(blk);
  assign drop_sat = drop_sum[FRAME_W] ? '1 : drop_sum[FRAME_W-1:0];
  assign fits     = (cap_sum <= {1'b0, max_capture_frames}) &&
                    (entry_count != CNT_W'(LOG_DEPTH));
  assign do_store = cmd.exec && (op == OP_STAMP) && fits;

  // Write on stored stamps, registered read every cycle
  always_ff @(posedge clk) begin
    if (do_store) mem[entry_count[IDX_W-1:0]] <= {t, captured_frames};
    rdata <= mem[raddr];
  end

  // Signed magnitudes for setup
  logic             ntn, ndt, nfd;
  logic [TIME_W-1:0]  tmag, dmag, d0mag;
  logic [FRAME_W-1:0] fmag;

  assign ntn   = t < a_time;
  assign tmag  = ntn ? (a_time - t) : (t - a_time);
  assign ndt   = b_time < a_time;
  assign dmag  = ndt ? (a_time - b_time) : (b_time - a_time);
  assign nfd   = b_frame < a_frame;
  assign fmag  = nfd ? (a_frame - b_frame) : (b_frame - a_frame);
  assign d0mag = tmag;

  // Multiply and divide steps
  logic [WORD_W:0]   mul_sum;
  logic [WORD_W-1:0] rem_sh;
  logic              rem_ge;

  assign mul_sum = {1'b0, prod[PROD_W-1:WORD_W]} +
                   (prod[0] ? {1'b0, mcand} : '0);
  assign rem_sh  = {rem[WORD_W-2:0], prod[PROD_W-1]};
  assign rem_ge  = rem_sh >= WORD_W'(divisor);

  // Rounding
  logic              round_up;
  logic [WORD_W-1:0] mag_pair;
  logic [WORD_W-1:0] mag_single;

  assign round_up   = rem >= (WORD_W'(divisor) - rem);
  assign mag_single = prod[95:32] + WORD_W'(prod[31]);
  always_comb begin
    if (prod[PROD_W-1:WORD_W] != '0) mag_pair = '1;
    else if (round_up && (prod[WORD_W-1:0] == '1)) mag_pair = '1;
    else mag_pair = prod[WORD_W-1:0] + WORD_W'(round_up);
  end

  // Combine base with signed magnitude, saturate to the output range
  localparam logic [OUT_W:0]   MAG_CAP = (OUT_W+1)'(1) << OUT_W;
  localparam logic [OUT_W+1:0] POS_MAX = ((OUT_W+2)'(1) << (OUT_W-1)) - 1'b1;
  localparam logic [OUT_W:0]   NEG_CAP = (OUT_W+1)'(1) << (OUT_W-1);

  logic [OUT_W:0]   magc;
  logic [OUT_W+1:0] pos_sum;
  logic [OUT_W:0]   neg_d;
  logic [OUT_W:0]   neg_dc;
  logic [OUT_W-1:0] comb_res;

  assign magc    = (mag > WORD_W'(MAG_CAP)) ? MAG_CAP : mag[OUT_W:0];
  assign pos_sum = (OUT_W+2)'(base) + (OUT_W+2)'(magc);
  assign neg_d   = magc - (OUT_W+1)'(base);
  assign neg_dc  = (neg_d > NEG_CAP) ? NEG_CAP : neg_d;
  always_comb begin
    if (!neg) begin
      comb_res = (pos_sum > POS_MAX) ? POS_MAX[OUT_W-1:0] : pos_sum[OUT_W-1:0];
    end else if (magc <= (OUT_W+1)'(base)) begin
      comb_res = OUT_W'(base) - magc[OUT_W-1:0];
    end else begin
      comb_res = ~neg_dc[OUT_W-1:0] + 1'b1;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      frames_per_ns_q32  <= FPN_RESET;
      block_frames       <= BLK_RESET;
      max_capture_frames <= MAX_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_FPN: frames_per_ns_q32  <= cfg_data[FPN_W-1:0];
        CFG_BLK: block_frames       <= cfg_data[BLK_W-1:0];
        CFG_MAX: max_capture_frames <= cfg_data[FRAME_W-1:0];
        default: ;
      endcase
    end
  end

  // Log counts: advance on store, grow dropped on a rejected stamp, zero on clear
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count     <= '0;
      captured_frames <= '0;
      dropped_frames  <= '0;
    end else if (cmd.exec) begin
      case (op)
        OP_STAMP: begin
          if (fits) begin
            entry_count     <= entry_count + CNT_W'(1);
            captured_frames <= cap_sum[FRAME_W-1:0];
          end else begin
            dropped_frames <= drop_sat;
          end
        end
        OP_CLEAR: begin
          entry_count     <= '0;
          captured_frames <= '0;
          dropped_frames  <= '0;
        end
        default: ;
      endcase
    end
  end

  // Capture the transaction
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op <= operation;
      t  <= host_time_ns;
    end
  end

  // Search bounds
  always_ff @(posedge clk) begin
    case (cmd.bound)
      BND_FIRST: begin
        lo <= '0;
        hi <= IDX_W'(1);
      end
      BND_LAST: begin
        lo <= n_m2[IDX_W-1:0];
        hi <= n_m1[IDX_W-1:0];
      end
      BND_FULL: begin
        lo <= '0;
        hi <= n_m1[IDX_W-1:0];
      end
      BND_NARROW: begin
        if (rd_time <= t) lo <= mid;
        else hi <= mid;
      end
      default: ;
    endcase
  end

  // Neighbor entries
  always_ff @(posedge clk) begin
    if (cmd.lat_a) begin
      a_time  <= rd_time;
      a_frame <= rd_frame;
    end
    if (cmd.lat_b) begin
      b_time  <= rd_time;
      b_frame <= rd_frame;
    end
  end

  // Serial multiply, divide and rounding
  always_ff @(posedge clk) begin
    if (cmd.setup_single) begin
      mcand  <= WORD_W'(d0mag);
      prod   <= PROD_W'(frames_per_ns_q32);
      neg    <= ntn;
      base   <= a_frame;
      single <= 1'b1;
      mag    <= '0;
      rem    <= '0;
      step   <= MUL_LAST;
    end else if (cmd.setup_pair) begin
      mcand   <= WORD_W'(tmag);
      prod    <= PROD_W'(fmag);
      divisor <= dmag;
      neg     <= ntn ^ ndt ^ nfd;
      base    <= a_frame;
      single  <= 1'b0;
      mag     <= '0;
      rem     <= '0;
      step    <= MUL_LAST;
    end else if (cmd.mul_step) begin
      prod <= {mul_sum, prod[WORD_W-1:1]};
      step <= (step == '0) ? DIV_LAST : step - 1'b1;
    end else if (cmd.div_step) begin
      rem  <= rem_ge ? (rem_sh - WORD_W'(divisor)) : rem_sh;
      prod <= {prod[PROD_W-2:0], rem_ge};
      step <= step - 1'b1;
    end else if (cmd.rnd) begin
      mag <= single ? mag_single : mag_pair;
    end
  end

  // Result register and strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.emit_query ||
              (cmd.exec && !(op == OP_QUERY && entry_count != '0));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      frame_index   <= '0;
      frame_valid   <= 1'b0;
      block_stored  <= 1'b0;
      dropped_total <= dropped_frames;
      case (op)
        OP_STAMP: begin
          if (fits) begin
            frame_index  <= OUT_W'(captured_frames);
            frame_valid  <= 1'b1;
            block_stored <= 1'b1;
          end else begin
            dropped_total <= drop_sat;
          end
        end
        OP_CLEAR: dropped_total <= '0;
        default: ;
      endcase
    end else if (cmd.emit_query) begin
      frame_index   <= comb_res;
      frame_valid   <= 1'b1;
      block_stored  <= 1'b0;
      dropped_total <= dropped_frames;
    end
  end

  // Status to the sequencer
  always_comb begin
    stat.op         = op;
    stat.count_zero = (entry_count == '0);
    stat.count_one  = (entry_count == CNT_W'(1));
    stat.t_le_rd    = (t <= rd_time);
    stat.t_ge_rd    = (t >= rd_time);
    stat.span_gt1   = ({1'b0, hi} > ({1'b0, lo} + (IDX_W+1)'(1)));
    stat.dmag_zero  = (a_time == b_time);
    stat.step_zero  = (step == '0);
    stat.single     = single;
  end

endmodule

`default_nettype wire
